/* hdl/gpiolk_pkg.sv */
// Shared types, register codes and pin constants for the GPIO port with configuration lock.
package gpiolk_pkg;

   localparam int PIN_COUNT = 16;
   localparam int PIN_W = 16;
   localparam int FIELD_W = 4;
   localparam int PINS_PER_CR = 8;
   localparam int KEY_POS = 16;

   localparam logic [PIN_W-1:0] PIN_MASK = PIN_W'((33'd1 << PIN_COUNT) - 33'd1);
   localparam logic [31:0] CR_RESET = 32'h4444_4444;

   localparam logic CMD_READ = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [2:0] REG_CRL = 3'd0;
   localparam logic [2:0] REG_CRH = 3'd1;
   localparam logic [2:0] REG_IDR = 3'd2;
   localparam logic [2:0] REG_ODR = 3'd3;
   localparam logic [2:0] REG_BSRR = 3'd4;
   localparam logic [2:0] REG_BRR = 3'd5;
   localparam logic [2:0] REG_LCKR = 3'd6;

   typedef struct packed {
      logic        cmd;
      logic [2:0]  reg_sel;
      logic [31:0] write_data;
      logic [15:0] pin_levels;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [15:0] drive_levels;
      logic        lock_active;
   } rsp_type;

   typedef struct packed {
      logic             wr_en;
      logic             rd_en;
      logic             key;
      logic [PIN_W-1:0] bits;
   } lock_req_type;

   typedef struct packed {
      logic             locked;
      logic             locked_next;
      logic [PIN_W-1:0] bits;
   } lock_status_type;

endpackage

/* hdl/gpio_port_with_lock_core.sv */
// Top level of the sixteen-pin GPIO port with configuration lock.
//
// Each request word is one bus access: a read or write of CRL, CRH, IDR, ODR,
// BSRR, BRR or LCKR, together with the sampled pin levels. Every request
// gives exactly one response word carrying the read value (zero on writes),
// the output latch after the access and the lock status.
// Both channels use valid and ready handshakes. The access is decoded and
// the register file updated in the cycle the request is accepted, and the
// response word is held in an output register, so it appears in the cycle after
// acceptance. One request is accepted every cycle while the response side
// keeps up; the single output register sets that rate.
// When the receiver stalls, the response stays in the output register and a
// new request is taken only in a cycle where that register empties.
// Reset sets both configuration registers to 0x44444444 (floating inputs),
// clears the output latch, the lock bits and the lock sequence, and empties
// the output register.
module gpio_port_with_lock_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  gpiolk_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output gpiolk_pkg::rsp_type rsp_data
);

   logic [31:0]                  cfg_low_ff;
   logic [31:0]                  cfg_low_in;
   logic [31:0]                  cfg_high_ff;
   logic [31:0]                  cfg_high_in;
   logic [gpiolk_pkg::PIN_W-1:0] odr_ff;
   logic [gpiolk_pkg::PIN_W-1:0] odr_in;
   logic                         rsp_valid_ff;
   gpiolk_pkg::rsp_type          rsp_ff;
   gpiolk_pkg::rsp_type          rsp_in;
   logic                         accept;
   logic                         is_write;
   logic [31:0]                  cfg_low_wr;
   logic [31:0]                  cfg_high_wr;
   logic [31:0]                  read_value;
   gpiolk_pkg::lock_req_type     lock_req;
   gpiolk_pkg::lock_status_type  lock_status;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign is_write = (req_data.cmd == gpiolk_pkg::CMD_WRITE);

   assign lock_req.wr_en = accept && is_write && req_data.reg_sel == gpiolk_pkg::REG_LCKR;
   assign lock_req.rd_en = accept && !is_write && req_data.reg_sel == gpiolk_pkg::REG_LCKR;
   assign lock_req.key = req_data.write_data[gpiolk_pkg::KEY_POS];
   assign lock_req.bits = req_data.write_data[gpiolk_pkg::PIN_W-1:0] & gpiolk_pkg::PIN_MASK;

   gpiolk_lock u_lock (
      .clock       (clock),
      .reset       (reset),
      .lock_req    (lock_req),
      .lock_status (lock_status)
   );

   // Merge the written fields of present, unlocked pins into CRL and CRH.
   always_comb begin
      cfg_low_wr = cfg_low_ff;
      cfg_high_wr = cfg_high_ff;
      for (int i = 0; i < gpiolk_pkg::PINS_PER_CR; i++) begin
         if (i < gpiolk_pkg::PIN_COUNT
             && !(lock_status.locked && lock_status.bits[i])) begin
            cfg_low_wr[i*gpiolk_pkg::FIELD_W +: gpiolk_pkg::FIELD_W] =
               req_data.write_data[i*gpiolk_pkg::FIELD_W +: gpiolk_pkg::FIELD_W];
         end
         if (i + gpiolk_pkg::PINS_PER_CR < gpiolk_pkg::PIN_COUNT
             && !(lock_status.locked && lock_status.bits[i + gpiolk_pkg::PINS_PER_CR])) begin
            cfg_high_wr[i*gpiolk_pkg::FIELD_W +: gpiolk_pkg::FIELD_W] =
               req_data.write_data[i*gpiolk_pkg::FIELD_W +: gpiolk_pkg::FIELD_W];
         end
      end
   end

   always_comb begin
      cfg_low_in = cfg_low_ff;
      cfg_high_in = cfg_high_ff;
      odr_in = odr_ff;
      read_value = '0;
      if (accept && is_write) begin
         case (req_data.reg_sel)
            gpiolk_pkg::REG_CRL: cfg_low_in = cfg_low_wr;
            gpiolk_pkg::REG_CRH: cfg_high_in = cfg_high_wr;
            gpiolk_pkg::REG_ODR: begin
               odr_in = req_data.write_data[gpiolk_pkg::PIN_W-1:0] & gpiolk_pkg::PIN_MASK;
            end
            gpiolk_pkg::REG_BSRR: begin
               odr_in = ((odr_ff & ~req_data.write_data[31:16])
                         | req_data.write_data[15:0]) & gpiolk_pkg::PIN_MASK;
            end
            gpiolk_pkg::REG_BRR: begin
               odr_in = odr_ff & ~req_data.write_data[15:0] & gpiolk_pkg::PIN_MASK;
            end
            default: ;
         endcase
      end else if (accept) begin
         case (req_data.reg_sel)
            gpiolk_pkg::REG_CRL: read_value = cfg_low_ff;
            gpiolk_pkg::REG_CRH: read_value = cfg_high_ff;
            gpiolk_pkg::REG_IDR: begin
               read_value = {16'd0, req_data.pin_levels & gpiolk_pkg::PIN_MASK};
            end
            gpiolk_pkg::REG_ODR: read_value = {16'd0, odr_ff};
            gpiolk_pkg::REG_LCKR: begin
               read_value = {15'd0, lock_status.locked, lock_status.bits};
            end
            default: read_value = '0;
         endcase
      end
   end

   assign rsp_in.read_data = read_value;
   assign rsp_in.drive_levels = odr_in;
   assign rsp_in.lock_active = lock_status.locked_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_low_ff <= gpiolk_pkg::CR_RESET;
         cfg_high_ff <= gpiolk_pkg::CR_RESET;
         odr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_low_ff <= cfg_low_in;
         cfg_high_ff <= cfg_high_in;
         odr_ff <= odr_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // A write always answers with a zero read word.
   a_write_reads_zero: assert property (@(posedge clock) disable iff (reset)
      accept && is_write |=> rsp_ff.read_data == 32'd0)
      else $error("write produced a nonzero read word");

   // The reported latch matches the latch register after the access.
   a_latch_match: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_ff.drive_levels == odr_ff)
      else $error("response latch differs from output latch");

   // The lock flag in the response follows the lock state.
   a_lock_match: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_ff.lock_active == lock_status.locked)
      else $error("response lock flag differs from lock state");

endmodule

/* hdl/gpiolk_lock.sv */
// Lock key sequencer and lock bit register of the GPIO port.
module gpiolk_lock (
   input  logic                      clock,
   input  logic                      reset,
   input  gpiolk_pkg::lock_req_type  lock_req,
   output gpiolk_pkg::lock_status_type lock_status
);

   typedef enum logic [1:0] {
      STEP_IDLE,
      STEP_ONE,
      STEP_TWO,
      STEP_THREE
   } step_type;

   step_type                     step_ff;
   logic                         lock_key_ff;
   logic [gpiolk_pkg::PIN_W-1:0] lock_bits_ff;
   logic                         same;

   assign same = (lock_req.bits == lock_bits_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
         lock_key_ff <= 1'b0;
         lock_bits_ff <= '0;
      end else if (!lock_key_ff) begin
         if (lock_req.wr_en) begin
            lock_bits_ff <= lock_req.bits;
            if (step_ff == STEP_ONE && !lock_req.key && same) begin
               step_ff <= STEP_TWO;
            end else if (step_ff == STEP_TWO && lock_req.key && same) begin
               step_ff <= STEP_THREE;
            end else if (lock_req.key) begin
               step_ff <= STEP_ONE;
            end else begin
               step_ff <= STEP_IDLE;
            end
         end else if (lock_req.rd_en) begin
            if (step_ff == STEP_THREE) begin
               lock_key_ff <= 1'b1;
            end
            step_ff <= STEP_IDLE;
         end
      end
   end

   assign lock_status.locked = lock_key_ff;
   assign lock_status.locked_next = lock_key_ff | (lock_req.rd_en && step_ff == STEP_THREE);
   assign lock_status.bits = lock_bits_ff;

   // Once armed, the key stays armed until reset.
   a_key_sticky: assert property (@(posedge clock) disable iff (reset)
      lock_key_ff |=> lock_key_ff)
      else $error("lock key dropped while armed");

   // The lock bits are frozen while the key is armed.
   a_bits_frozen: assert property (@(posedge clock) disable iff (reset)
      lock_key_ff |=> $stable(lock_bits_ff))
      else $error("lock bits changed while locked");

   // Arming happens only on a read that completes the sequence.
   a_arm_source: assert property (@(posedge clock) disable iff (reset)
      !lock_key_ff && lock_key_ff != lock_status.locked_next |=>
         lock_key_ff && step_ff == STEP_IDLE)
      else $error("lock armed outside a completed sequence");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the GPIO port with configuration lock core.
module testbench;

   localparam logic [2:0] REG_SPARE = 3'd7;
   localparam int STALL_LIMIT = 2000;
   localparam int WORDS_UNLOCKED = 520;
   localparam int WORDS_TOTAL = 900;

   typedef enum logic [1:0] {
      KEY_IDLE,
      KEY_WROTE_ONE,
      KEY_WROTE_ZERO,
      KEY_READY
   } key_stage_type;

   typedef struct packed {
      gpiolk_pkg::req_type word;
      logic                typed;
      gpiolk_pkg::rsp_type reply;
   } directed_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   gpiolk_pkg::req_type req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   gpiolk_pkg::rsp_type rsp_data;

   logic [31:0]                  crl_q = gpiolk_pkg::CR_RESET;
   logic [31:0]                  crh_q = gpiolk_pkg::CR_RESET;
   logic [gpiolk_pkg::PIN_W-1:0] odr_q = '0;
   logic [gpiolk_pkg::PIN_W-1:0] lock_bits_q = '0;
   logic                         lock_armed_q = 1'b0;
   key_stage_type                lock_stage_q = KEY_IDLE;

   gpiolk_pkg::rsp_type pending_replies[$];
   directed_row_type    directed_rows[$];
   gpiolk_pkg::rsp_type oldest;
   int                  words_sent = 0;
   int                  mismatches = 0;
   int                  stall_cycles = 0;
   logic                steady = 1'b0;
   logic                keep_unlocked = 1'b1;

   gpio_port_with_lock_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   function automatic logic [31:0] merge_config(input logic [31:0] old,
                                                input logic [31:0] data, input int first_pin);
      logic [31:0] merged;
      int pin;
      merged = old;
      for (int i = 0; i < gpiolk_pkg::PINS_PER_CR; i++) begin
         pin = first_pin + i;
         if (pin < gpiolk_pkg::PIN_COUNT && !(lock_armed_q && lock_bits_q[pin]))
            merged[i*gpiolk_pkg::FIELD_W +: gpiolk_pkg::FIELD_W] =
               data[i*gpiolk_pkg::FIELD_W +: gpiolk_pkg::FIELD_W];
      end
      return merged;
   endfunction

   function automatic gpiolk_pkg::rsp_type gpio_access(input gpiolk_pkg::req_type a);
      gpiolk_pkg::rsp_type r;
      logic [gpiolk_pkg::PIN_W-1:0] bits;
      logic key;
      r = '0;
      bits = a.write_data[gpiolk_pkg::PIN_W-1:0] & gpiolk_pkg::PIN_MASK;
      key = a.write_data[gpiolk_pkg::KEY_POS];
      if (a.cmd == gpiolk_pkg::CMD_WRITE) begin
         case (a.reg_sel)
            gpiolk_pkg::REG_CRL: crl_q = merge_config(crl_q, a.write_data, 0);
            gpiolk_pkg::REG_CRH: begin
               crh_q = merge_config(crh_q, a.write_data, gpiolk_pkg::PINS_PER_CR);
            end
            gpiolk_pkg::REG_ODR: odr_q = a.write_data[15:0] & gpiolk_pkg::PIN_MASK;
            gpiolk_pkg::REG_BSRR: begin
               odr_q = ((odr_q & ~a.write_data[31:16]) | a.write_data[15:0])
                       & gpiolk_pkg::PIN_MASK;
            end
            gpiolk_pkg::REG_BRR: begin
               odr_q = odr_q & ~a.write_data[15:0] & gpiolk_pkg::PIN_MASK;
            end
            gpiolk_pkg::REG_LCKR: begin
               if (!lock_armed_q) begin
                  if (lock_stage_q == KEY_WROTE_ONE && !key && bits == lock_bits_q)
                     lock_stage_q = KEY_WROTE_ZERO;
                  else if (lock_stage_q == KEY_WROTE_ZERO && key && bits == lock_bits_q)
                     lock_stage_q = KEY_READY;
                  else
                     lock_stage_q = key ? KEY_WROTE_ONE : KEY_IDLE;
                  lock_bits_q = bits;
               end
            end
            default: ;
         endcase
      end else begin
         case (a.reg_sel)
            gpiolk_pkg::REG_CRL: r.read_data = crl_q;
            gpiolk_pkg::REG_CRH: r.read_data = crh_q;
            gpiolk_pkg::REG_IDR: begin
               r.read_data = {16'b0, a.pin_levels & gpiolk_pkg::PIN_MASK};
            end
            gpiolk_pkg::REG_ODR: r.read_data = {16'b0, odr_q};
            gpiolk_pkg::REG_LCKR: begin
               r.read_data = {15'b0, lock_armed_q, lock_bits_q};
               if (!lock_armed_q) begin
                  if (lock_stage_q == KEY_READY)
                     lock_armed_q = 1'b1;
                  lock_stage_q = KEY_IDLE;
               end
            end
            default: r.read_data = '0;
         endcase
      end
      r.drive_levels = odr_q;
      r.lock_active = lock_armed_q;
      return r;
   endfunction

   function automatic gpiolk_pkg::req_type access(input logic cmd, input logic [2:0] sel,
                                                  input logic [31:0] data,
                                                  input logic [15:0] pins);
      gpiolk_pkg::req_type w;
      w.cmd = cmd;
      w.reg_sel = sel;
      w.write_data = data;
      w.pin_levels = pins;
      return w;
   endfunction

   function automatic gpiolk_pkg::rsp_type make_reply(input logic [31:0] rd,
                                                      input logic [15:0] drive,
                                                      input logic locked);
      gpiolk_pkg::rsp_type r;
      r.read_data = rd;
      r.drive_levels = drive;
      r.lock_active = locked;
      return r;
   endfunction

   function automatic void add_row(input gpiolk_pkg::req_type w, input logic typed,
                                   input gpiolk_pkg::rsp_type reply);
      directed_row_type row;
      row.word = w;
      row.typed = typed;
      row.reply = reply;
      directed_rows.push_back(row);
   endfunction

   function automatic gpiolk_pkg::req_type random_access(input logic allow_lock);
      gpiolk_pkg::req_type w;
      w.cmd = 1'($urandom_range(0, 1));
      w.reg_sel = 3'($urandom_range(0, 7));
      if (!allow_lock && w.reg_sel == gpiolk_pkg::REG_LCKR)
         w.reg_sel = REG_SPARE;
      w.write_data = $urandom;
      w.pin_levels = 16'($urandom);
      return w;
   endfunction

   task automatic send_word(input gpiolk_pkg::req_type w, input logic use_typed,
                            input gpiolk_pkg::rsp_type typed);
      gpiolk_pkg::rsp_type predicted;
      if (keep_unlocked && w.cmd == gpiolk_pkg::CMD_READ
          && w.reg_sel == gpiolk_pkg::REG_LCKR && lock_stage_q == KEY_READY)
         w.cmd = gpiolk_pkg::CMD_WRITE;
      while (!steady && $urandom_range(0, 99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      predicted = gpio_access(w);
      pending_replies.push_back(use_typed ? typed : predicted);
      words_sent++;
   endtask

   task automatic send_lock_sequence(input logic [15:0] bits, input logic allow_faults);
      logic [15:0] step_bits;
      logic key;
      for (int step = 0; step < 3; step++) begin
         key = (step != 1);
         step_bits = bits;
         if (allow_faults && $urandom_range(0, 99) < 12)
            key = ~key;
         if (allow_faults && $urandom_range(0, 99) < 12)
            step_bits = step_bits ^ 16'($urandom_range(1, 65535));
         repeat ($urandom_range(0, 2)) send_word(random_access(1'b0), 1'b0, '0);
         send_word(access(gpiolk_pkg::CMD_WRITE, gpiolk_pkg::REG_LCKR,
                          {15'($urandom), key, step_bits}, 16'($urandom)), 1'b0, '0);
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %h, actual %h", $time, field, want, got);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 21);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            mismatches++;
            $display("%0t: word with nothing expected, expected none, actual %h",
                     $time, rsp_data);
         end else begin
            oldest = pending_replies.pop_front();
            check_field("read_data", oldest.read_data, rsp_data.read_data);
            check_field("drive_levels", 32'(oldest.drive_levels), 32'(rsp_data.drive_levels));
            check_field("lock_active", 32'(oldest.lock_active), 32'(rsp_data.lock_active));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
         $display("gpio_port_with_lock_core regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;

      add_row(access(gpiolk_pkg::CMD_READ, gpiolk_pkg::REG_CRL, 32'hffff_ffff, 16'h0000),
              1'b1, make_reply(gpiolk_pkg::CR_RESET, 16'h0000, 1'b0));
      add_row(access(gpiolk_pkg::CMD_READ, gpiolk_pkg::REG_CRH, 32'h0000_0000, 16'hffff),
              1'b1, make_reply(gpiolk_pkg::CR_RESET, 16'h0000, 1'b0));
      add_row(access(gpiolk_pkg::CMD_READ, gpiolk_pkg::REG_IDR, 32'h0000_0000, 16'hffff),
              1'b1, make_reply(32'h0000_ffff, 16'h0000, 1'b0));
      add_row(access(gpiolk_pkg::CMD_READ, gpiolk_pkg::REG_IDR, 32'hffff_ffff, 16'h0000),
              1'b1, make_reply(32'h0000_0000, 16'h0000, 1'b0));
      add_row(access(gpiolk_pkg::CMD_WRITE, gpiolk_pkg::REG_IDR, 32'hffff_ffff, 16'hffff),
              1'b1, make_reply(32'h0000_0000, 16'h0000, 1'b0));
      add_row(access(gpiolk_pkg::CMD_WRITE, gpiolk_pkg::REG_ODR, 32'hffff_ffff, 16'h0000),
              1'b1, make_reply(32'h0000_0000, 16'hffff, 1'b0));
      add_row(access(gpiolk_pkg::CMD_READ, gpiolk_pkg::REG_ODR, 32'h0000_0000, 16'h0000),
              1'b1, make_reply(32'h0000_ffff, 16'hffff, 1'b0));
      add_row(access(gpiolk_pkg::CMD_WRITE, gpiolk_pkg::REG_BSRR, 32'hffff_0000, 16'h0000),
              1'b1, make_reply(32'h0000_0000, 16'h0000, 1'b0));
      add_row(access(gpiolk_pkg::CMD_WRITE, gpiolk_pkg::REG_BSRR, 32'hffff_ffff, 16'h0000),
              1'b1, make_reply(32'h0000_0000, 16'hffff, 1'b0));
      add_row(access(gpiolk_pkg::CMD_READ, gpiolk_pkg::REG_BSRR, 32'hffff_ffff, 16'h0000),
              1'b1, make_reply(32'h0000_0000, 16'hffff, 1'b0));
      add_row(access(gpiolk_pkg::CMD_WRITE, gpiolk_pkg::REG_BRR, 32'h0000_ffff, 16'h0000),
              1'b1, make_reply(32'h0000_0000, 16'h0000, 1'b0));
      add_row(access(gpiolk_pkg::CMD_READ, gpiolk_pkg::REG_BRR, 32'hffff_ffff, 16'hffff),
              1'b1, make_reply(32'h0000_0000, 16'h0000, 1'b0));
      add_row(access(gpiolk_pkg::CMD_WRITE, REG_SPARE, 32'hffff_ffff, 16'hffff),
              1'b1, make_reply(32'h0000_0000, 16'h0000, 1'b0));
      add_row(access(gpiolk_pkg::CMD_READ, REG_SPARE, 32'hffff_ffff, 16'hffff),
              1'b1, make_reply(32'h0000_0000, 16'h0000, 1'b0));
      add_row(access(gpiolk_pkg::CMD_WRITE, gpiolk_pkg::REG_CRL, 32'hffff_ffff, 16'h0000),
              1'b0, '0);
      add_row(access(gpiolk_pkg::CMD_WRITE, gpiolk_pkg::REG_CRH, 32'h0000_0000, 16'h0000),
              1'b0, '0);
      add_row(access(gpiolk_pkg::CMD_READ, gpiolk_pkg::REG_CRL, 32'h0000_0000, 16'h0000),
              1'b0, '0);
      add_row(access(gpiolk_pkg::CMD_READ, gpiolk_pkg::REG_CRH, 32'h0000_0000, 16'h0000),
              1'b0, '0);
      add_row(access(gpiolk_pkg::CMD_WRITE, gpiolk_pkg::REG_LCKR, 32'h0001_a5a5, 16'h0000),
              1'b0, '0);
      add_row(access(gpiolk_pkg::CMD_WRITE, gpiolk_pkg::REG_LCKR, 32'h0000_a5a5, 16'h0000),
              1'b0, '0);
      add_row(access(gpiolk_pkg::CMD_WRITE, gpiolk_pkg::REG_LCKR, 32'h0001_5a5a, 16'h0000),
              1'b0, '0);
      add_row(access(gpiolk_pkg::CMD_READ, gpiolk_pkg::REG_LCKR, 32'h0000_0000, 16'h0000),
              1'b1, make_reply(32'h0000_5a5a, 16'h0000, 1'b0));
      add_row(access(gpiolk_pkg::CMD_WRITE, gpiolk_pkg::REG_LCKR, 32'h0001_ffff, 16'h0000),
              1'b0, '0);
      add_row(access(gpiolk_pkg::CMD_WRITE, gpiolk_pkg::REG_LCKR, 32'h0000_ffff, 16'h0000),
              1'b0, '0);
      add_row(access(gpiolk_pkg::CMD_WRITE, gpiolk_pkg::REG_LCKR, 32'hffff_ffff, 16'h0000),
              1'b0, '0);
      add_row(access(gpiolk_pkg::CMD_WRITE, gpiolk_pkg::REG_LCKR, 32'h0000_0000, 16'h0000),
              1'b0, '0);
      add_row(access(gpiolk_pkg::CMD_READ, gpiolk_pkg::REG_LCKR, 32'h0000_0000, 16'h0000),
              1'b1, make_reply(32'h0000_0000, 16'h0000, 1'b0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].reply);

      // While unlocked, key sequences run up to their last step but are never armed.
      while (words_sent < WORDS_UNLOCKED) begin
         if ($urandom_range(0, 99) < 45) begin
            send_lock_sequence(16'($urandom), 1'b1);
            send_word(access(1'($urandom_range(0, 1)), gpiolk_pkg::REG_LCKR, $urandom,
                             16'($urandom)), 1'b0, '0);
         end else begin
            send_word(random_access(1'b1), 1'b0, '0);
         end
         steady = (words_sent >= 200 && words_sent < 330);
      end

      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);

      keep_unlocked = 1'b0;
      send_lock_sequence(16'($urandom), 1'b0);
      send_word(access(gpiolk_pkg::CMD_READ, gpiolk_pkg::REG_LCKR, $urandom, 16'($urandom)),
                1'b0, '0);

      while (words_sent < WORDS_TOTAL) begin
         if ($urandom_range(0, 99) < 40) begin
            send_word(access(gpiolk_pkg::CMD_WRITE,
                             3'($urandom_range(gpiolk_pkg::REG_CRL, gpiolk_pkg::REG_CRH)),
                             $urandom, 16'($urandom)), 1'b0, '0);
         end else if ($urandom_range(0, 99) < 25) begin
            send_lock_sequence(16'($urandom), 1'b1);
            send_word(access(1'($urandom_range(0, 1)), gpiolk_pkg::REG_LCKR, $urandom,
                             16'($urandom)), 1'b0, '0);
         end else begin
            send_word(random_access(1'b1), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("gpio_port_with_lock_core regression: pass");
      else
         $display("gpio_port_with_lock_core regression: fail");
      $finish;
   end

endmodule
